>>> rtl/core/scsp_pkg.sv
package scsp_pkg;

	// Fixed sizes of the programming word and the frequency result.
	localparam int unsigned NUM_CLOCKS = 4;
	localparam int unsigned CLK_IDX_W  = 2;
	localparam int unsigned FREQ_W     = 34;
	localparam int unsigned MAG_W      = 33;
	localparam int unsigned DEN_W      = 14;
	localparam int unsigned WORD_W     = 25;
	localparam int unsigned CNT_W      = 6;

	// Protocol constants of the serial port.
	localparam logic [4:0] WORD_BITS  = 5'd26;
	localparam logic [2:0] UNLOCK_MIN = 3'd5;
	localparam logic [2:0] ONES_MAX   = 3'd7;

	// Twice the reference clock in Hz.
	localparam logic [24:0] REF2_HZ = 25'd28636368;

	// One restoring step per magnitude bit of the quotient.
	localparam logic [CNT_W-1:0] DIV_STEPS = 6'd33;

	// Operation codes and the target that loads the doubling mask.
	localparam logic       OP_WRITE   = 1'b0;
	localparam logic       OP_READ    = 1'b1;
	localparam logic [2:0] TGT_DMASK  = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_PUSH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic mul;
		logic div_step;
		logic finish;
		logic push;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

>>> rtl/core/scsp_ctrl.sv
module scsp_ctrl
	import scsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd,
	output state_t  state
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = status.need_div ? ST_MUL : ST_PUSH;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_PUSH;
			end
			ST_PUSH: begin
				if (status.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule

>>> rtl/core/scsp_dp.sv
module scsp_dp
	import scsp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output status_t                  status,
	input  logic                     in_op,
	input  logic [1:0]               in_pins,
	input  logic [CLK_IDX_W-1:0]     in_idx,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic signed [FREQ_W-1:0] out_freq,
	output logic                     out_done,
	output logic [2:0]               out_tgt,
	output logic                     out_err
);

	// Port state.
	logic              last_clk_q;
	logic              unlocked_q;
	logic [2:0]        ones_q;
	logic [4:0]        bitcnt_q;
	logic [WORD_W-1:0] shift_q;
	logic [NUM_CLOCKS-1:0] mask_q;
	logic signed [FREQ_W-1:0] store_q [NUM_CLOCKS];

	// Pending result.
	logic signed [FREQ_W-1:0] res_freq_q;
	logic                     res_done_q;
	logic [2:0]               res_tgt_q;
	logic                     res_err_q;

	// Arithmetic registers.
	logic [WORD_W-1:0]  word_q;
	logic               dbl_q;
	logic               sign_q;
	logic [MAG_W-1:0]   quo_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic [CNT_W-1:0]   cnt_q;

	// Output register.
	logic                     out_valid_q;
	logic signed [FREQ_W-1:0] out_freq_q;
	logic                     out_done_q;
	logic [2:0]               out_tgt_q;
	logic                     out_err_q;

	// Next port state for a pin write.
	logic              is_write;
	logic              clk_pin;
	logic              dat_pin;
	logic              rise;
	logic              unl_d;
	logic [2:0]        ones_d;
	logic [4:0]        cnt_d;
	logic [WORD_W-1:0] sw_d;
	logic              done;
	logic [2:0]        tgt;
	logic              q_zero;

	assign is_write = (in_op == OP_WRITE);
	assign clk_pin  = in_pins[0];
	assign dat_pin  = in_pins[1];
	assign rise     = is_write && clk_pin && !last_clk_q;

	always_comb begin
		unl_d  = unlocked_q;
		ones_d = ones_q;
		cnt_d  = bitcnt_q;
		sw_d   = shift_q;
		done   = 1'b0;
		if (rise && !unlocked_q) begin
			if (dat_pin) begin
				if (ones_q != ONES_MAX) begin
					ones_d = ones_q + 3'd1;
				end
			end else if (ones_q >= UNLOCK_MIN) begin
				unl_d = 1'b1;
				cnt_d = 5'd0;
			end else begin
				ones_d = 3'd0;
			end
		end else if (rise) begin
			sw_d  = {dat_pin, shift_q[WORD_W-1:1]};
			cnt_d = bitcnt_q + 5'd1;
			done  = (cnt_d == WORD_BITS);
		end
	end

	assign tgt    = sw_d[23:21];
	assign q_zero = (sw_d[6:0] == 7'd2);

	// Operand magnitudes and signs from the captured word.
	logic [6:0]       q_raw;
	logic [6:0]       p_raw;
	logic             neg_q;
	logic             neg_p;
	logic [6:0]       q_mag;
	logic [6:0]       p_mag7;
	logic [7:0]       p_mag;
	logic [MAG_W-1:0] product;
	logic [DEN_W-1:0] den;

	assign q_raw   = word_q[6:0];
	assign p_raw   = word_q[16:10];
	assign neg_q   = (q_raw < 7'd2);
	assign neg_p   = (p_raw < 7'd3);
	assign q_mag   = neg_q ? (7'd2 - q_raw) : (q_raw - 7'd2);
	assign p_mag7  = neg_p ? (7'd3 - p_raw) : (p_raw - 7'd3);
	assign p_mag   = dbl_q ? {p_mag7, 1'b0} : {1'b0, p_mag7};
	assign product = MAG_W'(p_mag) * MAG_W'(REF2_HZ);
	assign den     = DEN_W'(q_mag) << word_q[9:7];

	// One restoring division step.
	logic [DEN_W:0] shifted;
	logic [DEN_W:0] trial;

	assign shifted = {rem_q, quo_q[MAG_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	// Signed result of a finished division.
	logic signed [FREQ_W-1:0] fval;

	assign fval = sign_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	// Port state and the frequency store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_clk_q <= 1'b0;
			unlocked_q <= 1'b0;
			ones_q     <= '0;
			bitcnt_q   <= '0;
			shift_q    <= '0;
			mask_q     <= '0;
			for (int i = 0; i < NUM_CLOCKS; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			if (cmd.take && is_write) begin
				last_clk_q <= clk_pin;
				bitcnt_q   <= cnt_d;
				if (done) begin
					unlocked_q <= 1'b0;
					ones_q     <= '0;
					shift_q    <= '0;
					if (tgt == TGT_DMASK) begin
						mask_q <= sw_d[NUM_CLOCKS-1:0];
					end
					if (!tgt[2] && q_zero) begin
						store_q[tgt[CLK_IDX_W-1:0]] <= '0;
					end
				end else begin
					unlocked_q <= unl_d;
					ones_q     <= ones_d;
					shift_q    <= sw_d;
				end
			end
			if (cmd.finish) begin
				store_q[res_tgt_q[CLK_IDX_W-1:0]] <= fval;
			end
		end
	end

	// Pending result and arithmetic registers.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			res_freq_q <= is_write ? '0 : store_q[in_idx];
			res_done_q <= is_write && done;
			res_tgt_q  <= (is_write && done) ? tgt : 3'd0;
			res_err_q  <= is_write && done && !tgt[2] && q_zero;
			word_q     <= sw_d;
			dbl_q      <= mask_q[tgt[CLK_IDX_W-1:0]];
		end
		if (cmd.mul) begin
			quo_q  <= product;
			rem_q  <= '0;
			den_q  <= den;
			sign_q <= neg_p ^ neg_q;
			cnt_q  <= DIV_STEPS;
		end
		if (cmd.div_step) begin
			rem_q <= trial[DEN_W] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], ~trial[DEN_W]};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.finish) begin
			res_freq_q <= fval;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_freq_q <= res_freq_q;
			out_done_q <= res_done_q;
			out_tgt_q  <= res_tgt_q;
			out_err_q  <= res_err_q;
		end
	end

	assign status.need_div = is_write && done && !tgt[2] && !q_zero;
	assign status.div_last = (cnt_q == CNT_W'(1));
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_freq  = out_freq_q;
	assign out_done  = out_done_q;
	assign out_tgt   = out_tgt_q;
	assign out_err   = out_err_q;

endmodule

>>> rtl/core/serial_clock_synth_programmer_core.sv
// Channel   Direction  tdata                          tuser
// s_axis    in         [1:0] pins, [3:2] freq_index   [0] operation
// m_axis    out        [33:0] frequency_hz            [0] word_done, [3:1] word_target,
//                                                     [4] divide_error
//
// A read or a pin write that stores no frequency skips the multiplier and divider.
// A word for a frequency target with a nonzero divisor takes one multiply step,
// then 33 steps of the restoring divider, one sign fix, and the output load.
// Reset clears the port state, the doubling mask and the four stored frequencies.
// A stalled output holds its result; one further request is taken meanwhile and
// waits in the pending result register until the output frees.
module serial_clock_synth_programmer_core
	import scsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [1:0] pins, [3:2] freq_index
	input  logic [0:0]  s_tuser,  // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [33:0] frequency_hz
	output logic [4:0]  m_tuser   // [0] word_done, [3:1] word_target, [4] divide_error
);

	cmd_t    cmd;
	status_t status;
	state_t  state;

	logic signed [FREQ_W-1:0] out_freq;
	logic                     out_done;
	logic [2:0]               out_tgt;
	logic                     out_err;

	// Sequencer.
	scsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd),
		.state    (state)
	);

	// Port state, multiplier, divider and output register.
	scsp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_op     (s_tuser[0]),
		.in_pins   (s_tdata[1:0]),
		.in_idx    (s_tdata[3:2]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_freq  (out_freq),
		.out_done  (out_done),
		.out_tgt   (out_tgt),
		.out_err   (out_err)
	);

	assign m_tdata = {6'd0, out_freq};
	assign m_tuser = {out_err, out_tgt, out_done};

	// A divide error comes only with a finished word for a frequency target,
	// and it stores zero.
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[4] |-> m_tuser[0] && !m_tuser[3] && (m_tdata[33:0] == '0))
		else $error("divide error without a zero frequency word");

	// A target is reported only for a finished word.
	a_tgt_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tuser[3:1] == 3'd0))
		else $error("word target set without a finished word");

	// After a request is taken the block is not ready again in the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken in back-to-back cycles");

	// The divider leaves only through the sign fix.
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state == ST_DIV |=> state == ST_DIV || state == ST_FIN)
		else $error("divider left without finishing");

endmodule

>>> sim/testbench.sv
module testbench
	import scsp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint     REF_CLOCK_HZ   = 64'sd14318184;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         DRAIN_CYCLES   = 60;
	localparam int         RANDOM_ITEMS   = 90;
	localparam logic [2:0] TGT_SPARE_LO   = 3'd4;
	localparam logic [2:0] TGT_SPARE_MID  = 3'd5;
	localparam logic [2:0] TGT_SPARE_HI   = 3'd7;

	typedef struct {
		logic [FREQ_W-1:0] freq;
		logic              done;
		logic [2:0]        target;
		logic              div_err;
	} port_response_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [4:0]  m_tuser;

	// Shadow copy of the programming port state.
	logic              shadow_clk_pin;
	logic              shadow_unlocked;
	logic [2:0]        shadow_ones;
	logic [4:0]        shadow_bits;
	logic [WORD_W-1:0] shadow_word;
	logic [3:0]        shadow_dmask;
	longint            shadow_freqs [NUM_CLOCKS];

	port_response_t expected_responses [$];
	int  mismatch_count;
	int  request_count;
	int  words_done;
	int  freq_words;
	int  div_errors;
	int  reads_done;
	int  idle_cycles;
	bit  idle_on;

	serial_clock_synth_programmer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Frequency of a completed word; q of zero gives zero and an error flag.
	function automatic longint synth_frequency(logic [WORD_W-1:0] w, logic [1:0] target,
			output bit div_err);
		longint q;
		longint m;
		longint p;
		q = w[6:0];
		q = q - 2;
		m = 64'sd1 << w[9:7];
		p = w[16:10];
		p = p - 3;
		if (shadow_dmask[target])
			p = p * 2;
		div_err = (q == 0);
		if (div_err)
			return 0;
		return (p * 2 * REF_CLOCK_HZ) / (q * m);
	endfunction

	// Advances the shadow state by one request and returns the response it causes.
	function automatic port_response_t predict_port_response(logic op, logic [1:0] pins,
			logic [1:0] idx);
		port_response_t r;
		longint f;
		bit err;
		r = '{freq: '0, done: 1'b0, target: 3'd0, div_err: 1'b0};
		if (op == OP_READ) begin
			r.freq = shadow_freqs[idx][FREQ_W-1:0];
			reads_done++;
			return r;
		end
		if (pins[0] && !shadow_clk_pin) begin
			if (!shadow_unlocked) begin
				if (pins[1]) begin
					if (shadow_ones != ONES_MAX)
						shadow_ones = shadow_ones + 3'd1;
				end else if (shadow_ones >= UNLOCK_MIN) begin
					shadow_unlocked = 1'b1;
					shadow_bits = '0;
				end else begin
					shadow_ones = '0;
				end
			end else begin
				shadow_word = {pins[1], shadow_word[WORD_W-1:1]};
				shadow_bits = shadow_bits + 5'd1;
				if (shadow_bits == WORD_BITS) begin
					r.done = 1'b1;
					r.target = shadow_word[23:21];
					words_done++;
					if (r.target[2] == 1'b0) begin
						f = synth_frequency(shadow_word, r.target[1:0], err);
						shadow_freqs[r.target[1:0]] = f;
						r.freq = f[FREQ_W-1:0];
						r.div_err = err;
						freq_words++;
						if (err)
							div_errors++;
					end else if (r.target == TGT_DMASK) begin
						shadow_dmask = shadow_word[3:0];
					end
					shadow_ones = '0;
					shadow_word = '0;
					shadow_unlocked = 1'b0;
				end
			end
		end
		shadow_clk_pin = pins[0];
		return r;
	endfunction

	// Sends one request, after a random gap while idle_on is set, and records its expected response.
	task automatic send_request(input logic op, input logic [1:0] pins, input logic [1:0] idx);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, idx, pins};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		expected_responses.push_back(predict_port_response(op, pins, idx));
		request_count++;
	endtask

	task automatic pin_write(input logic clock_pin, input logic data_pin);
		send_request(OP_WRITE, {data_pin, clock_pin}, 2'($urandom_range(0, 3)));
	endtask

	task automatic read_frequency(input logic [1:0] idx);
		send_request(OP_READ, 2'($urandom_range(0, 3)), idx);
	endtask

	// One serial bit: clock low with any data, then clock high with the bit.
	// Now and then a read falls between the two, which must not count as an edge.
	task automatic clock_in_bit(input logic data_bit);
		pin_write(1'b0, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 15) == 0)
			read_frequency(2'($urandom_range(0, 3)));
		pin_write(1'b1, data_bit);
	endtask

	task automatic unlock_port(input int n_ones);
		repeat (n_ones) clock_in_bit(1'b1);
		clock_in_bit(1'b0);
	endtask

	// The first of the 26 bits falls out of the register, so it is junk.
	task automatic send_word(input logic [WORD_W-1:0] w);
		clock_in_bit(1'($urandom_range(0, 1)));
		for (int i = 0; i < WORD_W; i++)
			clock_in_bit(w[i]);
	endtask

	task automatic program_word(input int n_ones, input logic [WORD_W-1:0] w);
		unlock_port(n_ones);
		send_word(w);
	endtask

	function automatic logic [WORD_W-1:0] build_word(logic [2:0] target, logic [6:0] p_field,
			logic [2:0] m_shift, logic [6:0] q_field);
		logic [WORD_W-1:0] w;
		w = WORD_W'($urandom);
		w[23:21] = target;
		w[16:10] = p_field;
		w[9:7] = m_shift;
		w[6:0] = q_field;
		return w;
	endfunction

	task automatic read_all_frequencies();
		for (int i = 0; i < NUM_CLOCKS; i++)
			read_frequency(2'(i));
	endtask

	task automatic test_reads_after_reset();
		read_all_frequencies();
	endtask

	// Repeated clock highs, a short run of ones, then a proper unlock and word.
	task automatic test_unlock_sequence();
		pin_write(1'b1, 1'b1);
		pin_write(1'b1, 1'b1);
		pin_write(1'b0, 1'b0);
		pin_write(1'b1, 1'b1);
		repeat (2) clock_in_bit(1'b1);
		clock_in_bit(1'b0);
		pin_write(1'b0, 1'b1);
		read_frequency(2'd0);
		pin_write(1'b1, 1'b1);
		program_word(5, build_word(3'd0, 7'd40, 3'd1, 7'd20));
		read_frequency(2'd0);
	endtask

	// Largest magnitudes need the doubling bit, so the mask is loaded first.
	task automatic test_frequency_extremes();
		program_word(6, build_word(TGT_DMASK, 7'h00, 3'd0, 7'h0f));
		program_word(5, build_word(3'd0, 7'h7f, 3'd0, 7'd3));
		program_word(7, build_word(3'd1, 7'h7f, 3'd0, 7'd1));
		program_word(9, build_word(3'd2, 7'h00, 3'd7, 7'h7f));
		program_word(5, build_word(3'd3, 7'h55, 3'd2, 7'd2));
		read_all_frequencies();
	endtask

	// Mask bits select doubling per target; a spare target leaves everything alone.
	task automatic test_mask_and_spare_targets();
		program_word(5, build_word(TGT_DMASK, 7'h00, 3'd0, 7'h05));
		for (int t = 0; t < NUM_CLOCKS; t++)
			program_word(5, build_word(3'(t), 7'd100, 3'd3, 7'd9));
		program_word(6, build_word(TGT_SPARE_LO, 7'h7f, 3'd0, 7'd2));
		read_all_frequencies();
	endtask

	function automatic logic [WORD_W-1:0] random_word();
		logic [2:0] target;
		logic [6:0] q_field;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			target = 3'($urandom_range(0, 3));
		else if (pick < 8)
			target = TGT_DMASK;
		else
			case ($urandom_range(0, 2))
				0: target = TGT_SPARE_LO;
				1: target = TGT_SPARE_MID;
				default: target = TGT_SPARE_HI;
			endcase
		pick = $urandom_range(0, 7);
		if (pick == 0)
			q_field = 7'd2;
		else if (pick == 1)
			q_field = 7'($urandom_range(0, 3));
		else
			q_field = 7'($urandom);
		return build_word(target, 7'($urandom), 3'($urandom), q_field);
	endfunction

	// Mostly complete programming words, with reads, pin noise and aborted unlocks.
	task automatic test_random_traffic();
		int start_count;
		int pick;
		start_count = request_count;
		while (request_count - start_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				idle_on = !idle_on;
			pick = $urandom_range(0, 19);
			if (pick < 12) begin
				program_word($urandom_range(5, 9), random_word());
				if ($urandom_range(0, 1) == 0)
					read_frequency(2'($urandom_range(0, 3)));
			end else if (pick < 15) begin
				repeat ($urandom_range(1, 3)) read_frequency(2'($urandom_range(0, 3)));
			end else if (pick < 18) begin
				repeat ($urandom_range(1, 6)) pin_write(1'($urandom), 1'($urandom));
			end else begin
				unlock_port($urandom_range(0, 4));
			end
		end
		idle_on = 1'b1;
	endtask

	// Output side: random stall, while idle_on is set, before each response is taken.
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			stall = idle_on ? $urandom_range(0, 4) : 0;
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(arst_n && m_tvalid && m_tready));
		end
	end

	// Compare each accepted response with the oldest expected one.
	always @(posedge clk) begin : check_responses
		port_response_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_responses.size() == 0) begin
				$error("response with none expected: frequency_hz %0d, tuser %h",
					$signed(m_tdata[FREQ_W-1:0]), m_tuser);
				mismatch_count++;
			end else begin
				want = expected_responses.pop_front();
				if (m_tdata[FREQ_W-1:0] !== want.freq) begin
					$error("frequency_hz: expected %0d, actual %0d",
						$signed(want.freq), $signed(m_tdata[FREQ_W-1:0]));
					mismatch_count++;
				end
				if (m_tuser[0] !== want.done) begin
					$error("word_done: expected %0d, actual %0d", want.done, m_tuser[0]);
					mismatch_count++;
				end
				if (m_tuser[3:1] !== want.target) begin
					$error("word_target: expected %0d, actual %0d", want.target, m_tuser[3:1]);
					mismatch_count++;
				end
				if (m_tuser[4] !== want.div_err) begin
					$error("divide_error: expected %0d, actual %0d", want.div_err, m_tuser[4]);
					mismatch_count++;
				end
			end
		end
	end

	// Stop the run if neither side moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		mismatch_count = 0;
		request_count = 0;
		words_done = 0;
		freq_words = 0;
		div_errors = 0;
		reads_done = 0;
		idle_cycles = 0;
		shadow_clk_pin = 1'b0;
		shadow_unlocked = 1'b0;
		shadow_ones = '0;
		shadow_bits = '0;
		shadow_word = '0;
		shadow_dmask = '0;
		for (int i = 0; i < NUM_CLOCKS; i++)
			shadow_freqs[i] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reads_after_reset();
		test_unlock_sequence();
		test_frequency_extremes();
		test_mask_and_spare_targets();
		test_random_traffic();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d reads, %0d completed words.",
			request_count, reads_done, words_done);
		$display("Of those words %0d set a frequency and %0d hit a zero divisor.",
			freq_words, div_errors);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
